>>> rtl/core/acr_pkg.sv
// shared constants, codes and types of the adaptive cubic resampler
package acr_pkg;

  // default parameter values
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_CHANNELS    = 2;

  // request type codes
  localparam logic REQ_FILL   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // configuration register indexes
  localparam int          CFG_IDX_W   = 4;
  localparam logic [3:0]  CFG_TARGET  = 4'd0;
  localparam logic [3:0]  CFG_NOMINAL = 4'd1;
  localparam int          CFG_DATA_W  = 32;

  // register reset values and limits
  localparam logic [15:0] TARGET_RESET = 16'd512;
  localparam logic [15:0] TARGET_MIN   = 16'd64;
  localparam logic [31:0] NOMINAL_RESET = 32'd268435456;
  localparam logic [31:0] NOM_MIN  = 32'd26843546;
  localparam logic [31:0] NOM_MAX  = 32'd2684354560;
  localparam logic [31:0] NOM_HYST = 32'd134218;

  // loop gains and clamps, Q0.31
  localparam int KI_Q31    = 10737;
  localparam int KP_Q31    = 42950;
  localparam int INT_LIM   = 10737418;
  localparam int DELTA_LIM = 42949673;

  // ratio smoothing weights, Q0.16
  localparam int W_OLD = 64225;
  localparam int W_NEW = 1311;

  // phase
  localparam logic [32:0] PHASE_ONE = 33'h010000000;
  localparam logic [3:0]  MAX_OUT   = 4'd11;

  // request queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        we;
    logic [3:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic        avail;
    logic        is_fill;
    logic [15:0] fill;
  } req_head_t;

endpackage

>>> rtl/core/acr_ifs.sv
// request and result channel interfaces
interface acr_in_if #(parameter int SAMPLE_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [15:0]            buffer_fill;
  logic [SAMPLE_BITS-1:0] sample_ch0;
  logic [SAMPLE_BITS-1:0] sample_ch1;
  modport source (output valid, req_type, buffer_fill, sample_ch0, sample_ch1, input ready);
  modport sink (input valid, req_type, buffer_fill, sample_ch0, sample_ch1, output ready);
endinterface

interface acr_out_if #(parameter int SAMPLE_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] out_ch0;
  logic [SAMPLE_BITS-1:0] out_ch1;
  logic                   last;
  modport source (output valid, out_ch0, out_ch1, last, input ready);
  modport sink (input valid, out_ch0, out_ch1, last, output ready);
endinterface

>>> rtl/core/acr_front.sv
// front end: accepts requests, classifies them and queues them for the back end
module acr_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  acr_in_if.sink                 in_ch,
  input  logic                   pop,
  output acr_pkg::req_head_t     head,
  output logic [SAMPLE_BITS-1:0] head_s0,
  output logic [SAMPLE_BITS-1:0] head_s1,
  output logic [1:0]             q_count
);
  import acr_pkg::*;

  logic                   fill_q_r [QUEUE_DEPTH];
  logic [15:0]            bf_q_r   [QUEUE_DEPTH];
  logic [SAMPLE_BITS-1:0] s0_q_r   [QUEUE_DEPTH];
  logic [SAMPLE_BITS-1:0] s1_q_r   [QUEUE_DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_ch.ready = (count_r != 2'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fill_q_r[wr_ptr_r] <= (in_ch.req_type == REQ_FILL);
      bf_q_r[wr_ptr_r]   <= in_ch.buffer_fill;
      s0_q_r[wr_ptr_r]   <= in_ch.sample_ch0;
      s1_q_r[wr_ptr_r]   <= in_ch.sample_ch1;
    end
  end

  assign head.avail   = (count_r != 2'd0);
  assign head.is_fill = fill_q_r[rd_ptr_r];
  assign head.fill    = bf_q_r[rd_ptr_r];
  assign head_s0      = s0_q_r[rd_ptr_r];
  assign head_s1      = s1_q_r[rd_ptr_r];
  assign q_count      = count_r;

endmodule

>>> rtl/core/acr_back.sv
// back end: drift loop, history, phase stepping and catmull-rom interpolation
module acr_back #(
  parameter int SAMPLE_BITS = 24,
  parameter int CHANNELS    = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  acr_pkg::cfg_wr_t       cfg,
  input  acr_pkg::req_head_t     head,
  input  logic [SAMPLE_BITS-1:0] head_s0,
  input  logic [SAMPLE_BITS-1:0] head_s1,
  output logic                   pop,
  acr_out_if.source              out_ch
);
  import acr_pkg::*;

  localparam int CW    = SAMPLE_BITS + 4;
  localparam int ACC_W = SAMPLE_BITS + 14;
  localparam int PW    = ACC_W + 17;
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic LAST_CH = 1'(CHANNELS - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_F_MUL   = 4'd1;
  localparam logic [3:0] ST_F_INT   = 4'd2;
  localparam logic [3:0] ST_F_DELTA = 4'd3;
  localparam logic [3:0] ST_F_TGT   = 4'd4;
  localparam logic [3:0] ST_F_MIX   = 4'd5;
  localparam logic [3:0] ST_F_SUM   = 4'd6;
  localparam logic [3:0] ST_E_LOAD  = 4'd7;
  localparam logic [3:0] ST_E_MUL   = 4'd8;
  localparam logic [3:0] ST_E_ADD   = 4'd9;
  localparam logic [3:0] ST_E_FIN   = 4'd10;
  localparam logic [3:0] ST_E_OUT   = 4'd11;

  logic [3:0]  state_r;
  logic [15:0] target_r;
  logic [31:0] nominal_r, current_r;
  logic signed [31:0] integ_r;
  logic [32:0] phase_r;
  logic [SAMPLE_BITS-1:0] hist_r [2][4];

  logic signed [16:0] err_r;
  logic signed [31:0] pi_r;
  logic signed [33:0] pp_r;
  logic [31:0] factor_r, tgt_r;
  logic [47:0] mix_a_r, mix_b_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PW-1:0]    prod_r;
  logic [1:0] step_r;
  logic       ch_r;
  logic [3:0] n_r;
  logic [SAMPLE_BITS-1:0] y_r [2];

  logic                   out_valid_r, out_last_r;
  logic [SAMPLE_BITS-1:0] out_ch0_r, out_ch1_r;

  // config decode
  logic [31:0] nom_diff;
  logic        nom_take;
  assign nom_diff = (cfg.data > nominal_r) ? cfg.data - nominal_r : nominal_r - cfg.data;
  assign nom_take = cfg.we && (cfg.index == CFG_NOMINAL) && (cfg.data >= NOM_MIN)
                    && (cfg.data <= NOM_MAX) && (nom_diff > NOM_HYST);

  // fill path arithmetic
  logic signed [33:0] int_sum;
  logic signed [34:0] delta_sum, delta_cl;
  logic [63:0] tgt_prod;
  logic [48:0] mix_sum;
  assign int_sum   = 34'(integ_r) + 34'(pi_r);
  assign delta_sum = 35'(pp_r) + 35'(integ_r);
  assign delta_cl  = (delta_sum > 35'(DELTA_LIM)) ? 35'(DELTA_LIM) :
                     (delta_sum < -35'(DELTA_LIM)) ? -35'(DELTA_LIM) : delta_sum;
  assign tgt_prod  = 64'(nominal_r) * 64'(factor_r);
  assign mix_sum   = 49'(mix_a_r) + 49'(mix_b_r) + 49'd32768;

  // interpolation coefficients of the channel in work
  logic signed [CW-1:0] y0, y1, y2, y3, c0, c1, c2;
  logic signed [ACC_W-1:0] cterm, acc_sum, y_fin, y_sat;
  logic signed [16:0] mu_s;
  assign y0 = CW'($signed(hist_r[ch_r][0]));
  assign y1 = CW'($signed(hist_r[ch_r][1]));
  assign y2 = CW'($signed(hist_r[ch_r][2]));
  assign y3 = CW'($signed(hist_r[ch_r][3]));
  assign c0 = CW'(-y0 + 3 * y1 - 3 * y2 + y3);
  assign c1 = CW'(2 * y0 - 5 * y1 + 4 * y2 - y3);
  assign c2 = CW'(y2 - y0);
  assign mu_s = $signed({1'b0, phase_r[27:12]});

  always_comb begin
    case (step_r)
      2'd0:    cterm = ACC_W'(c1) <<< 8;
      2'd1:    cterm = ACC_W'(c2) <<< 8;
      default: cterm = '0;
    endcase
  end

  assign acc_sum = ACC_W'(prod_r >>> 16) + cterm;
  assign y_fin   = ((acc_r + ACC_W'(256)) >>> 9) + ACC_W'(y1);
  assign y_sat   = (y_fin > Y_MAX) ? Y_MAX : (y_fin < Y_MIN) ? Y_MIN : y_fin;

  // output frame step
  logic        out_free;
  logic [32:0] ph_next;
  logic [3:0]  n_next;
  logic        frame_last;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign ph_next    = phase_r + 33'(current_r);
  assign n_next     = n_r + 4'd1;
  assign frame_last = (ph_next[32:28] != 5'd0) || (n_next == MAX_OUT);

  assign pop = (state_r == ST_IDLE) && head.avail;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= TARGET_RESET;
      nominal_r   <= NOMINAL_RESET;
      current_r   <= NOMINAL_RESET;
      integ_r     <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg.we && cfg.index == CFG_TARGET)
        target_r <= (cfg.data[15:0] < TARGET_MIN) ? TARGET_MIN : cfg.data[15:0];
      if (nom_take) begin
        nominal_r <= cfg.data;
        current_r <= cfg.data;
        integ_r   <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head.avail) begin
            if (head.is_fill) begin
              state_r <= ST_F_MUL;
            end else if (phase_r[32:28] != 5'd0) begin
              phase_r <= phase_r - PHASE_ONE;
            end else begin
              state_r <= ST_E_LOAD;
            end
          end
        end
        ST_F_MUL:   state_r <= ST_F_INT;
        ST_F_INT: begin
          integ_r <= (int_sum > 34'(INT_LIM)) ? 32'(INT_LIM) :
                     (int_sum < -34'(INT_LIM)) ? -32'(INT_LIM) : 32'(int_sum);
          state_r <= ST_F_DELTA;
        end
        ST_F_DELTA: state_r <= ST_F_TGT;
        ST_F_TGT:   state_r <= ST_F_MIX;
        ST_F_MIX:   state_r <= ST_F_SUM;
        ST_F_SUM: begin
          current_r <= mix_sum[47:16];
          state_r   <= ST_IDLE;
        end
        ST_E_LOAD:  state_r <= ST_E_MUL;
        ST_E_MUL:   state_r <= ST_E_ADD;
        ST_E_ADD:   state_r <= (step_r == 2'd2) ? ST_E_FIN : ST_E_MUL;
        ST_E_FIN:   state_r <= (ch_r == LAST_CH) ? ST_E_OUT : ST_E_LOAD;
        ST_E_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (frame_last) begin
              phase_r <= ((ph_next[32:28] != 5'd0) ? ph_next : PHASE_ONE) - PHASE_ONE;
              state_r <= ST_IDLE;
            end else begin
              phase_r <= ph_next;
              state_r <= ST_E_LOAD;
            end
          end
        end
        default:    state_r <= ST_IDLE;
      endcase
    end
  end

  // sample history, cleared at reset, shifted on every sample request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        for (int k = 0; k < 4; k++) begin
          hist_r[i][k] <= '0;
        end
      end
    end else if ((state_r == ST_IDLE) && head.avail && !head.is_fill) begin
      for (int k = 0; k < 3; k++) begin
        hist_r[0][k] <= hist_r[0][k+1];
        hist_r[1][k] <= hist_r[1][k+1];
      end
      hist_r[0][3] <= head_s0;
      hist_r[1][3] <= head_s1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        err_r <= $signed({1'b0, head.fill}) - $signed({1'b0, target_r});
        n_r   <= 4'd0;
        ch_r  <= 1'b0;
      end
      ST_F_MUL: begin
        pi_r <= 32'(34'(err_r) * 34'(KI_Q31));
        pp_r <= 34'(err_r) * 34'(KP_Q31);
      end
      ST_F_DELTA: factor_r <= 32'(delta_cl + 35'sd2147483648);
      ST_F_TGT:   tgt_r <= tgt_prod[63] ? '1 : tgt_prod[62:31];
      ST_F_MIX: begin
        mix_a_r <= 48'(current_r) * 48'(W_OLD);
        mix_b_r <= 48'(tgt_r) * 48'(W_NEW);
      end
      ST_E_LOAD: begin
        acc_r  <= ACC_W'(c0) <<< 8;
        step_r <= 2'd0;
      end
      ST_E_MUL: prod_r <= PW'(acc_r) * PW'(mu_s);
      ST_E_ADD: begin
        acc_r  <= acc_sum;
        step_r <= step_r + 2'd1;
      end
      ST_E_FIN: begin
        y_r[ch_r] <= y_sat[SAMPLE_BITS-1:0];
        ch_r      <= ~ch_r;
      end
      ST_E_OUT: begin
        ch_r <= 1'b0;
        if (out_free) begin
          out_ch0_r  <= y_r[0];
          out_ch1_r  <= (CHANNELS > 1) ? y_r[1] : '0;
          out_last_r <= frame_last;
          n_r        <= n_next;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_ch0 = out_ch0_r;
  assign out_ch.out_ch1 = out_ch1_r;
  assign out_ch.last    = out_last_r;

endmodule

>>> rtl/core/adaptive_cubic_resampler_unit.sv
// top level of the adaptive stereo catmull-rom resampler
// fill request: the back end steps through pop, two products, integral, delta, 32x32 target, mix, sum
// sample request: a pop and phase step-down when the phase skips a frame, else per output frame
//   (per channel: coefficient load, three multiply/add passes of one shared multiplier, final
//   round and saturate; then the frame goes to the output register once it is free), 11 frames max
// a two-entry request queue lets requests arrive while the back end works or the output stalls
// reset: synchronous active-low rst_n clears history, phase, integral, queue and output valid,
//   and loads register defaults (target 512, nominal and current ratio 1.0)
module adaptive_cubic_resampler_unit #(
  parameter int SAMPLE_BITS = acr_pkg::DEF_SAMPLE_BITS,
  parameter int CHANNELS    = acr_pkg::DEF_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  acr_in_if.sink                           in_ch,
  acr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [acr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import acr_pkg::*;

  // configuration write bundle for the back end
  cfg_wr_t cfg;
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // queue head and pop between front and back
  req_head_t              head;
  logic [SAMPLE_BITS-1:0] head_s0, head_s1;
  logic                   pop;
  logic [1:0]             q_count;

  // front: accepts and classifies requests into the queue
  acr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .pop     (pop),
    .head    (head),
    .head_s0 (head_s0),
    .head_s1 (head_s1),
    .q_count (q_count)
  );

  // back: drift loop on fill requests, interpolation on sample requests
  acr_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNELS    (CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .head    (head),
    .head_s0 (head_s0),
    .head_s1 (head_s1),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // no result is pending right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // an accepted request is in the queue on the next cycle
  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (q_count != 2'd0))
    else $error("accepted request lost from queue");

  // the back end never pops an empty queue
  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_count != 2'd0))
    else $error("pop from empty queue");

endmodule

>>> test/adaptive_cubic_resampler_unit_test.sv
// self-checking testbench for the adaptive cubic resampler top level
module adaptive_cubic_resampler_unit_test;
  import acr_pkg::*;

  localparam int SBITS      = 24;
  localparam int IDLE_LIMIT = 3000;  // cycles with no handshake on either side
  localparam int LONG_HOLD  = 300;   // receiver hold-off in the pressure test
  localparam int SETTLE     = 40;    // wait after the last frame for queued fills to finish

  // one expected output frame
  typedef struct packed {
    logic [SBITS-1:0] ch0;
    logic [SBITS-1:0] ch1;
    logic             last;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  acr_in_if #(.SAMPLE_BITS(SBITS)) in_bus ();
  acr_out_if #(.SAMPLE_BITS(SBITS)) out_bus ();

  adaptive_cubic_resampler_unit #(.SAMPLE_BITS(SBITS), .CHANNELS(2)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state: registers, per-channel history, phase and the drift loop
  logic [15:0] target_frames;
  logic [31:0] nominal_step;
  logic [31:0] step_ratio;
  longint      drift_integral;
  longint      frame_hist [2][4];
  longint      phase_acc;

  frame_t pending_frames [$];
  int     mismatches = 0;
  int     requests_sent = 0;
  int     frames_checked = 0;
  int     fills_sent = 0;
  int     hold_seq = 0;

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.req_type    = REQ_FILL;
    in_bus.buffer_fill = '0;
    in_bus.sample_ch0  = '0;
    in_bus.sample_ch1  = '0;
    out_bus.ready      = 1'b0;
  end

  function automatic void model_reset();
    target_frames  = TARGET_RESET;
    nominal_step   = NOMINAL_RESET;
    step_ratio     = NOMINAL_RESET;
    drift_integral = 0;
    phase_acc      = 0;
    foreach (frame_hist[c, k]) frame_hist[c][k] = 0;
  endfunction

  function automatic void model_config(logic [3:0] idx, logic [31:0] val);
    longint diff;
    if (idx == CFG_TARGET) begin
      target_frames = (val[15:0] < TARGET_MIN) ? TARGET_MIN : val[15:0];
    end else if (idx == CFG_NOMINAL) begin
      if (val < NOM_MIN || val > NOM_MAX) return;
      diff = (val > nominal_step) ? longint'(val) - longint'(nominal_step)
                                  : longint'(nominal_step) - longint'(val);
      if (diff > longint'(NOM_HYST)) begin
        nominal_step   = val;
        step_ratio     = val;
        drift_integral = 0;
      end
    end
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // pi loop on the fill error, then 0.98/0.02 smoothing toward the target ratio
  function automatic void model_fill_update(logic [15:0] fill);
    longint      err, delta;
    logic [63:0] goal, mixed;
    err = longint'(fill) - longint'(target_frames);
    drift_integral = clip(drift_integral + err * KI_Q31, -INT_LIM, INT_LIM);
    delta = clip(err * KP_Q31 + drift_integral, -DELTA_LIM, DELTA_LIM);
    goal = (64'(nominal_step) * 64'((64'sd1 <<< 31) + delta)) >> 31;
    if (goal > 64'hFFFF_FFFF) goal = 64'hFFFF_FFFF;
    mixed = (64'(step_ratio) * W_OLD + goal * W_NEW + 64'd32768) >> 16;
    step_ratio = mixed[31:0];
  endfunction

  // catmull-rom by horner with 8 guard bits, floor shifts, round half up
  function automatic longint cubic_point(int c, longint mu);
    longint y0, y1, y2, y3, k0, k1, k2, acc, lim;
    y0 = frame_hist[c][0]; y1 = frame_hist[c][1];
    y2 = frame_hist[c][2]; y3 = frame_hist[c][3];
    k0 = -y0 + 3 * y1 - 3 * y2 + y3;
    k1 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    k2 = y2 - y0;
    acc = k0 * 256;
    acc = ((acc * mu) >>> 16) + k1 * 256;
    acc = ((acc * mu) >>> 16) + k2 * 256;
    acc = (acc * mu) >>> 16;
    acc = ((acc + 256) >>> 9) + y1;
    lim = longint'(1) <<< (SBITS - 1);
    return clip(acc, -lim, lim - 1);
  endfunction

  function automatic void model_sample_push(logic [SBITS-1:0] s0, logic [SBITS-1:0] s1);
    int     n;
    longint one;
    longint v0, v1;
    frame_t f;
    n   = 0;
    one = longint'(PHASE_ONE);
    for (int k = 0; k < 3; k++) begin
      frame_hist[0][k] = frame_hist[0][k + 1];
      frame_hist[1][k] = frame_hist[1][k + 1];
    end
    frame_hist[0][3] = longint'($signed(s0));
    frame_hist[1][3] = longint'($signed(s1));
    while (phase_acc < one && n < MAX_OUT) begin
      v0 = cubic_point(0, phase_acc >> 12);
      v1 = cubic_point(1, phase_acc >> 12);
      f.ch0  = v0[SBITS-1:0];
      f.ch1  = v1[SBITS-1:0];
      f.last = 1'b0;
      pending_frames.push_back(f);
      n++;
      phase_acc += longint'(step_ratio);
    end
    if (n > 0) pending_frames[pending_frames.size() - 1].last = 1'b1;
    if (phase_acc < one) phase_acc = one;
    phase_acc -= one;
  endfunction

  // sender: valid stays high across back-to-back requests
  task automatic send_request(logic kind, logic [15:0] fill,
                              logic [SBITS-1:0] s0, logic [SBITS-1:0] s1);
    in_bus.valid       <= 1'b1;
    in_bus.req_type    <= kind;
    in_bus.buffer_fill <= fill;
    in_bus.sample_ch0  <= s0;
    in_bus.sample_ch1  <= s1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    requests_sent++;
    if (kind == REQ_FILL) begin
      fills_sent++;
      model_fill_update(fill);
    end else begin
      model_sample_push(s0, s1);
    end
  endtask

  task automatic send_fill(logic [15:0] fill);
    send_request(REQ_FILL, fill, SBITS'($urandom), SBITS'($urandom));
  endtask

  task automatic send_sample(logic [SBITS-1:0] s0, logic [SBITS-1:0] s1);
    send_request(REQ_SAMPLE, 16'($urandom), s0, s1);
  endtask

  task automatic sender_gap(int cycles);
    in_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every expected frame is out, then let queued fills finish
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_config(idx, val);
  endtask

  // mostly plausible audio, sometimes full-scale extremes
  function automatic logic [SBITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SBITS-1){1'b1}}};
      1: return {1'b1, {(SBITS-1){1'b0}}};
      default: return SBITS'($urandom);
    endcase
  endfunction

  // fill levels mostly near the target, sometimes far off
  function automatic logic [15:0] rand_fill();
    int t;
    t = int'(target_frames);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(clip(longint'(t) + $urandom_range(0, 64) - 32, 0, 65535));
  endfunction

  // extremes of sample values, saturation and a step at unit ratio
  task automatic test_sample_extremes();
    send_sample(24'h7FFFFF, 24'h800000);
    send_sample(24'h800000, 24'h7FFFFF);
    send_sample(24'h7FFFFF, 24'h800000);
    send_sample(24'h800000, 24'h7FFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'h555555, 24'hAAAAAA);
    drain();
  endtask

  // fill error extremes drive both the integral and the correction clamps
  task automatic test_fill_clamps();
    send_fill(16'hFFFF);
    send_fill(16'hFFFF);
    send_sample(rand_sample(), rand_sample());
    send_fill(16'h0000);
    send_fill(16'h0000);
    send_fill(16'h0000);
    send_sample(rand_sample(), rand_sample());
    send_fill(target_frames);
    drain();
  endtask

  // register writes that are clamped, ignored or below hysteresis
  task automatic test_register_corners();
    write_reg(CFG_TARGET, 32'd0);
    write_reg(CFG_TARGET, 32'hFFFF_FFFF);
    write_reg(CFG_NOMINAL, 32'(NOM_MIN) - 32'd1);
    write_reg(CFG_NOMINAL, 32'(NOM_MAX) + 32'd1);
    write_reg(CFG_NOMINAL, 32'hFFFF_FFFF);
    write_reg(CFG_NOMINAL, 32'(NOMINAL_RESET) + 32'(NOM_HYST));
    write_reg(4'(CFG_NOMINAL) + 4'd1, 32'(NOM_MIN));
    write_reg(4'hF, 32'd7);
    send_fill(16'd100);
    send_sample(rand_sample(), rand_sample());
    drain();
  endtask

  // slowest ratio pulled lower by an empty buffer hits the emission cap;
  // fastest makes the phase skip frames
  task automatic test_ratio_extremes();
    write_reg(CFG_NOMINAL, NOM_MIN);
    write_reg(CFG_TARGET, 32'hFFFF);
    send_fill(16'd0);
    send_fill(16'd0);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), rand_sample());
    drain();
    write_reg(CFG_NOMINAL, NOM_MAX);
    write_reg(CFG_TARGET, 32'(TARGET_MIN));
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), rand_sample());
    send_fill(16'd0);
    drain();
  endtask

  // random traffic in bursts under one register setting
  task automatic random_phase(logic [31:0] ratio, logic [15:0] tgt, int count);
    int burst;
    write_reg(CFG_NOMINAL, ratio);
    write_reg(CFG_TARGET, 32'(tgt));
    burst = $urandom_range(1, 20);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) send_fill(rand_fill());
      else send_sample(rand_sample(), rand_sample());
      if (--burst == 0) begin
        if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 12));
        burst = $urandom_range(1, 20);
      end
    end
    drain();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    write_reg(CFG_NOMINAL, 32'd134217728);
    hold_seq++;
    for (int i = 0; i < 20; i++) send_sample(rand_sample(), rand_sample());
    drain();
  endtask

  // receiver: random stall pattern, redrawn when the age counter wraps, plus long holds
  always @(posedge clk) begin : rx_ready
    static int mode = 0;
    static int age = 0;
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (++age == 64) begin
      age  = 0;
      mode = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      case (mode)
        0, 1: out_bus.ready <= 1'b1;
        2: out_bus.ready <= ($urandom_range(0, 1) == 0);
        default: out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // compare each accepted frame with the oldest expected one
  always @(posedge clk) begin : frame_check
    frame_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      frames_checked++;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame ch0=%h ch1=%h last=%b",
                   out_bus.out_ch0, out_bus.out_ch1, out_bus.last);
      end else begin
        want = pending_frames.pop_front();
        if (want.ch0 !== out_bus.out_ch0 || want.ch1 !== out_bus.out_ch1 ||
            want.last !== out_bus.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame %0d: expected ch0=%h ch1=%h last=%b, got ch0=%h ch1=%h last=%b",
                     frames_checked, want.ch0, want.ch1, want.last,
                     out_bus.out_ch0, out_bus.out_ch1, out_bus.last);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin : watchdog
    static int quiet = 0;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sample_extremes();
    test_fill_clamps();
    test_register_corners();
    test_ratio_extremes();
    random_phase(NOMINAL_RESET, 16'd512, 70);
    random_phase(32'd60000000, 16'd200, 60);
    random_phase(32'd500000000, 16'hFFFF, 60);
    random_phase(32'($urandom_range(100000000, 400000000)), 16'($urandom_range(64, 4000)), 70);
    test_backpressure();
    random_phase(NOM_MAX, 16'(TARGET_MIN), 30);

    $display("covered %0d requests (%0d fill updates) and %0d output frames",
             requests_sent, fills_sent, frames_checked);
    $display("ratios from minimum to maximum, clamped loop, cap and skip, long output stall");
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> adaptive_cubic_resampler_unit.f
rtl/core/acr_pkg.sv
rtl/core/acr_ifs.sv
rtl/core/acr_front.sv
rtl/core/acr_back.sv
rtl/core/adaptive_cubic_resampler_unit.sv
test/adaptive_cubic_resampler_unit_test.sv
